// ===== sv/cpac_pkg.sv =====
// Package for the cascaded PI attitude controller: codes, control word and microprogram.
`default_nettype none

package cpac_pkg;

  // Field widths
  localparam int unsigned AngleW   = 16;
  localparam int unsigned ErrLimW  = 15;
  localparam int unsigned IntLimW  = 20;
  localparam int unsigned IntegW   = 21;
  localparam int unsigned AGainW   = 8;
  localparam int unsigned QGainW   = 16;
  localparam int unsigned OutLimW  = 15;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned StepW    = 3;
  localparam int unsigned MulW     = 25;
  localparam int unsigned ProdW    = 2 * MulW;

  // Gyro scaling: floor(|g| * 100 / 9) = (|g| * GyroRecip) >> GyroShift for |g| <= 32768
  localparam int unsigned GyroShift = 20;
  localparam logic [23:0] GyroRecip = 24'd11650845;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PITCH_TARGET  = 3'd0,
    REG_ROLL_TARGET   = 3'd1,
    REG_ANGLE_ERR_LIM = 3'd2,
    REG_INTEG_LIM     = 3'd3,
    REG_ANGLE_GAIN    = 3'd4,
    REG_INTEG_GAIN    = 3'd5,
    REG_RATE_GAIN     = 3'd6,
    REG_OUTPUT_LIM    = 3'd7
  } cfg_reg_e;

  // Register reset values
  localparam logic [ErrLimW-1:0] AngleErrLimRst = 15'd4551;
  localparam logic [IntLimW-1:0] IntegLimRst    = 20'd364088;
  localparam logic [AGainW-1:0]  AngleGainRst   = 8'd2;
  localparam logic [QGainW-1:0]  IntegGainRst   = 16'd98;
  localparam logic [QGainW-1:0]  RateGainRst    = 16'd216;
  localparam logic [OutLimW-1:0] OutputLimRst   = 15'd250;

  // Datapath operation of one step
  typedef enum logic [5:0] {
    ALU_NOP   = 6'b000001,
    ALU_ERR   = 6'b000010,
    ALU_ACC   = 6'b000100,
    ALU_RTLD  = 6'b001000,
    ALU_RTSUM = 6'b010000,
    ALU_OUT   = 6'b100000
  } alu_op_e;

  // Multiplier operand pair of one step
  typedef enum logic [4:0] {
    MUL_NONE = 5'b00001,
    MUL_GYRO = 5'b00010,
    MUL_EAG  = 5'b00100,
    MUL_AIG  = 5'b01000,
    MUL_RATE = 5'b10000
  } mul_sel_e;

  // Sequencing: jump to the target when the condition holds, else advance
  typedef enum logic [3:0] {
    JMP_NEXT    = 4'b0001,
    JMP_IF_IDLE = 4'b0010,
    JMP_IF_AX0  = 4'b0100,
    JMP_IF_FULL = 4'b1000
  } jmp_e;

  typedef struct packed {
    alu_op_e          alu;
    mul_sel_e         mul;
    jmp_e             jmp;
    logic [StepW-1:0] tgt;
  } ucode_t;

  // Microprogram: one control word per step
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '{alu: ALU_NOP, mul: MUL_NONE, jmp: JMP_NEXT, tgt: 3'd0};
    case (step)
      3'd0: w = '{alu: ALU_NOP,   mul: MUL_NONE, jmp: JMP_IF_IDLE, tgt: 3'd0};
      3'd1: w = '{alu: ALU_ERR,   mul: MUL_GYRO, jmp: JMP_NEXT,    tgt: 3'd0};
      3'd2: w = '{alu: ALU_ACC,   mul: MUL_EAG,  jmp: JMP_NEXT,    tgt: 3'd0};
      3'd3: w = '{alu: ALU_RTLD,  mul: MUL_AIG,  jmp: JMP_NEXT,    tgt: 3'd0};
      3'd4: w = '{alu: ALU_RTSUM, mul: MUL_NONE, jmp: JMP_NEXT,    tgt: 3'd0};
      3'd5: w = '{alu: ALU_NOP,   mul: MUL_RATE, jmp: JMP_NEXT,    tgt: 3'd0};
      3'd6: w = '{alu: ALU_OUT,   mul: MUL_NONE, jmp: JMP_IF_AX0,  tgt: 3'd1};
      3'd7: w = '{alu: ALU_NOP,   mul: MUL_NONE, jmp: JMP_IF_FULL, tgt: 3'd7};
      default: w = '{alu: ALU_NOP, mul: MUL_NONE, jmp: JMP_NEXT, tgt: 3'd0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cascaded_pi_attitude_control_core.sv =====
// Top level of the cascaded PI attitude controller: microcoded sequencer and shared datapath.
//
//  Channel   Dir  Handshake                 Payload
//  s_axis    in   s_axis_tvalid/tready      pitch_angle, roll_angle, gyro_x, gyro_y
//  m_axis    out  m_axis_tvalid/tready      pitch_correction, roll_correction
//  cfg       in   cfg_we_i (no wait)        cfg_idx_i selects register, cfg_data_i value
//
//  One transaction runs from acceptance to its result in the output register through
//  six microcode steps per axis on the single shared 25x25 multiplier, plus the
//  publish step. s_axis_tready is high only in the wait step, so the next transaction
//  is taken at best in the cycle after the result is published.
//  A result still waiting on m_axis holds the sequencer in the publish step until it is taken.
//  Reset clears the step counter, integrators, output valid and loads register defaults.
`default_nettype none

module cascaded_pi_attitude_control_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pitch_angle[15:0], roll_angle[31:16], gyro_x[47:32], gyro_y[63:48]
  input  wire logic [63:0]                   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pitch_correction[15:0], roll_correction[31:16]
  output logic [31:0]                        m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [cpac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cpac_pkg::CfgDataW-1:0] cfg_data_i
);
  import cpac_pkg::*;

  // Configuration registers
  logic signed [AngleW-1:0] pitch_tgt_q, roll_tgt_q;
  logic [ErrLimW-1:0]       err_lim_q;
  logic [IntLimW-1:0]       int_lim_q;
  logic [AGainW-1:0]        ag_q;
  logic [QGainW-1:0]        ig_q, rg_q;
  logic [OutLimW-1:0]       out_lim_q;

  // Sequencer
  logic [StepW-1:0] step_q, step_d;
  logic             ax_q, ax_d;
  ucode_t           uw;

  // Datapath
  logic signed [AngleW-1:0] pa_q, ra_q, gx_q, gy_q;
  logic signed [IntegW-1:0] pitch_integ_q, roll_integ_q;
  logic signed [15:0]       err_q;
  logic signed [19:0]       gs_q;
  logic signed [MulW-1:0]   rt_q;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [15:0]       pitch_corr_q, roll_corr_q;
  logic                     out_valid_q;
  logic [31:0]              out_data_q;

  logic signed [AngleW-1:0] tgt_sel, ang_sel, gyro_sel;
  logic signed [IntegW-1:0] integ_sel;
  logic signed [16:0]       diff, err_lim_s;
  logic signed [15:0]       err_c;
  logic signed [21:0]       acc_sum, int_lim_s;
  logic signed [IntegW-1:0] acc_c;
  logic [16:0]              gyro_mag;
  logic [19:0]              gs_mag;
  logic signed [MulW-1:0]   out_pre, out_lim_s, rt_sum;
  logic signed [15:0]       out_c;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic                     in_acc, out_full, publish;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_full = out_valid_q & ~m_axis_tready;
  assign uw       = ucode_rom(step_q);
  assign publish  = (uw.jmp == JMP_IF_FULL) & ~out_full;

  assign s_axis_tready = (step_q == '0);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_tgt_q <= '0;
      roll_tgt_q  <= '0;
      err_lim_q   <= AngleErrLimRst;
      int_lim_q   <= IntegLimRst;
      ag_q        <= AngleGainRst;
      ig_q        <= IntegGainRst;
      rg_q        <= RateGainRst;
      out_lim_q   <= OutputLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PITCH_TARGET:  pitch_tgt_q <= cfg_data_i[AngleW-1:0];
        REG_ROLL_TARGET:   roll_tgt_q  <= cfg_data_i[AngleW-1:0];
        REG_ANGLE_ERR_LIM: err_lim_q   <= cfg_data_i[ErrLimW-1:0];
        REG_INTEG_LIM:     int_lim_q   <= cfg_data_i[IntLimW-1:0];
        REG_ANGLE_GAIN:    ag_q        <= cfg_data_i[AGainW-1:0];
        REG_INTEG_GAIN:    ig_q        <= cfg_data_i[QGainW-1:0];
        REG_RATE_GAIN:     rg_q        <= cfg_data_i[QGainW-1:0];
        REG_OUTPUT_LIM:    out_lim_q   <= cfg_data_i[OutLimW-1:0];
        default: ;
      endcase
    end
  end

  // Select the axis being worked on
  always_comb begin
    tgt_sel   = ax_q ? roll_tgt_q   : pitch_tgt_q;
    ang_sel   = ax_q ? ra_q         : pa_q;
    gyro_sel  = ax_q ? gy_q         : gx_q;
    integ_sel = ax_q ? roll_integ_q : pitch_integ_q;
  end

  // Clamp the angle error, formed wide so it cannot wrap
  always_comb begin
    diff      = 17'(tgt_sel) - 17'(ang_sel);
    err_lim_s = $signed({2'b00, err_lim_q});
    if (diff > err_lim_s)       err_c = 16'(err_lim_s);
    else if (diff < -err_lim_s) err_c = 16'(-err_lim_s);
    else                        err_c = 16'(diff);
  end

  // Clamp the integrator update
  always_comb begin
    acc_sum   = 22'(integ_sel) + 22'(err_q);
    int_lim_s = $signed({2'b00, int_lim_q});
    if (acc_sum > int_lim_s)       acc_c = IntegW'(int_lim_s);
    else if (acc_sum < -int_lim_s) acc_c = IntegW'(-int_lim_s);
    else                           acc_c = IntegW'(acc_sum);
  end

  // Gyro magnitude, scaled rate and rate target sum
  always_comb begin
    gyro_mag = gyro_sel[AngleW-1] ? 17'(-17'(gyro_sel)) : 17'(gyro_sel);
    gs_mag   = prod_q[GyroShift+19:GyroShift];
    rt_sum   = rt_q + MulW'($signed(prod_q[36:16])) - MulW'(gs_q);
  end

  // Clamp the motor correction
  always_comb begin
    out_pre   = prod_q[40:16];
    out_lim_s = $signed({10'd0, out_lim_q});
    if (out_pre > out_lim_s)       out_c = 16'(out_lim_s);
    else if (out_pre < -out_lim_s) out_c = 16'(-out_lim_s);
    else                           out_c = 16'(out_pre);
  end

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.mul)
      MUL_GYRO: begin
        mul_a = $signed({8'd0, gyro_mag});
        mul_b = $signed({1'b0, GyroRecip});
      end
      MUL_EAG: begin
        mul_a = MulW'(err_q);
        mul_b = $signed({17'd0, ag_q});
      end
      MUL_AIG: begin
        mul_a = MulW'(integ_sel);
        mul_b = $signed({9'd0, ig_q});
      end
      MUL_RATE: begin
        mul_a = rt_q;
        mul_b = $signed({9'd0, rg_q});
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  // Step counter and conditional jumps
  always_comb begin
    step_d = step_q + 3'd1;
    ax_d   = ax_q;
    unique case (uw.jmp)
      JMP_IF_IDLE: begin
        if (!in_acc) step_d = uw.tgt;
        ax_d = 1'b0;
      end
      JMP_IF_AX0: begin
        if (!ax_q) begin
          step_d = uw.tgt;
          ax_d   = 1'b1;
        end
      end
      JMP_IF_FULL: if (out_full) step_d = uw.tgt;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      ax_q   <= 1'b0;
    end else begin
      step_q <= step_d;
      ax_q   <= ax_d;
    end
  end

  // Hold the integrators across transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_integ_q <= '0;
      roll_integ_q  <= '0;
    end else if (uw.alu == ALU_ACC) begin
      if (ax_q) roll_integ_q  <= acc_c;
      else      pitch_integ_q <= acc_c;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_acc) begin
      pa_q <= s_axis_tdata[15:0];
      ra_q <= s_axis_tdata[31:16];
      gx_q <= s_axis_tdata[47:32];
      gy_q <= s_axis_tdata[63:48];
    end
    case (uw.alu)
      ALU_ERR:   err_q <= err_c;
      ALU_ACC:   gs_q  <= gyro_sel[AngleW-1] ? -$signed(gs_mag) : $signed(gs_mag);
      ALU_RTLD:  rt_q  <= prod_q[MulW-1:0];
      ALU_RTSUM: rt_q  <= rt_sum;
      ALU_OUT: begin
        if (ax_q) roll_corr_q  <= out_c;
        else      pitch_corr_q <= out_c;
      end
      default: ;
    endcase
    if (publish) out_data_q <= {roll_corr_q, pitch_corr_q};
  end

  // Output register valid: set on publish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q & ~m_axis_tready) | publish;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cpac_checker.sv =====
// Port-level checker for the cascaded PI attitude controller, bound to the top level.
`default_nettype none

module cpac_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One transaction at a time: input closes after acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A new result is published only from a busy sequencer
  a_publish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work");

  // Clamped corrections never reach the most negative code
  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000)
    else $error("correction out of range");

endmodule

bind cascaded_pi_attitude_control_core cpac_checker u_cpac_checker (.*);

`default_nettype wire
